// ----- rtl/rdb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdb_pkg: shared types for the reversible deque buffer
// Request kinds, controller states and the response beat layout.
// ----------------------------------------------------------------------------
package rdb_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        KIND_PUSH_HEAD = 2'd0,
        KIND_PUSH_TAIL = 2'd1,
        KIND_POP_HEAD  = 2'd2,
        KIND_REVERSE   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    typedef struct packed {
        logic   ok;
        t_value removed_value;
        t_count count;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/rdb_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdb_req_if: request channel
// valid/ready handshake carrying one deque request per beat.
// ----------------------------------------------------------------------------
interface rdb_req_if;
    logic           valid;
    logic           ready;
    rdb_pkg::t_kind  kind;
    rdb_pkg::t_value item_value;

    modport source (output valid, output kind, output item_value, input ready);
    modport sink   (input valid, input kind, input item_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/rdb_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdb_rsp_if: response channel
// valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface rdb_rsp_if;
    logic            valid;
    logic            ready;
    logic            ok;
    rdb_pkg::t_value removed_value;
    rdb_pkg::t_count count;

    modport source (output valid, output ok, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input ok, input removed_value, input count,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/rdb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdb_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module rdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/rdb_out_skid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdb_out_skid: response output register with one skid slot
// Holds a finished result while the sink stalls, so one more can land.
// ----------------------------------------------------------------------------
module rdb_out_skid (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire rdb_pkg::t_rsp i_data,
    output logic               o_skid_full,
    rdb_rsp_if.source          o_rsp
);

    logic          r_out_vld,  n_out_vld;
    logic          r_skid_vld, n_skid_vld;
    rdb_pkg::t_rsp r_out,      n_out;
    rdb_pkg::t_rsp r_skid,     n_skid;
    logic          out_take;

    assign out_take = r_out_vld && o_rsp.ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            // skid holds the older beat; it moves up first
            if (out_take) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid     = i_data;
                n_skid_vld = i_valid;
            end
        end else if (!r_out_vld || out_take) begin
            n_out     = i_data;
            n_out_vld = i_valid;
        end else if (i_valid) begin
            n_skid     = i_data;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_skid_full         = r_skid_vld;
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.ok            = r_out.ok;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.count         = r_out.count;

endmodule
`default_nettype wire

// ----- rtl/reversible_deque_buffer_unit.sv -----
// Insert, reverse and failed requests pass their result straight to the output
// register; a successful remove goes through the registered RAM read first.
// Throughput: 1 request per cycle for insert and reverse while the skid slot is free;
// a successful remove holds the next one off for the single port's registered read.
// Reset (synchronous, active low) clears head index, fill count, orientation
// and output valids; RAM contents are left as they are, with no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_deque_buffer_unit: bounded deque with reverse
// Ring store in a RAM; reverse flips an orientation flag, nothing moves.
// ----------------------------------------------------------------------------
module reversible_deque_buffer_unit #(
    parameter int DEPTH = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rdb_req_if.sink   i_req,
    rdb_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(DEPTH);

    rdb_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [FW-1:0]   r_fill,  n_fill;
    logic            r_rev,   n_rev;

    logic            req_ready;
    logic            req_accept;
    logic            skid_full;
    logic            rsp_valid;
    rdb_pkg::t_rsp   rsp_data;

    logic            mem_en;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [rdb_pkg::VALUE_W-1:0] mem_rdata;

    logic            full;
    logic            fill_nz;
    logic            put_low;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;
    logic [AW-1:0]   tail_off;
    logic [AW:0]     tail_sum;
    logic [AW-1:0]   tail_addr;

    assign req_ready   = (r_state == rdb_pkg::ST_IDLE) && !skid_full;
    assign i_req.ready = req_ready;
    assign req_accept  = i_req.valid && req_ready;

    assign full      = (r_fill == FILL_MAX);
    assign fill_nz   = (r_fill != '0);
    assign put_low   = (i_req.kind == rdb_pkg::KIND_PUSH_HEAD) != r_rev;
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;

    // far end of the run: front + fill (insert) or front + fill - 1 (remove)
    assign tail_off  = (i_req.kind == rdb_pkg::KIND_POP_HEAD) ? AW'(r_fill - 1'b1)
                                                              : AW'(r_fill);
    assign tail_sum  = {1'b0, r_front} + {1'b0, tail_off};
    assign tail_addr = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT)
                                               : AW'(tail_sum);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdb_pkg::ST_IDLE: begin
                if (req_accept && (i_req.kind == rdb_pkg::KIND_POP_HEAD) && fill_nz) begin
                    n_state = rdb_pkg::ST_READ;
                end
            end
            rdb_pkg::ST_READ: begin
                n_state = rdb_pkg::ST_IDLE;
            end
            default: begin
                n_state = rdb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_front                = r_front;
        n_fill                 = r_fill;
        n_rev                  = r_rev;
        mem_en                 = 1'b0;
        mem_we                 = 1'b0;
        mem_addr               = r_front;
        rsp_valid              = 1'b0;
        rsp_data.ok            = 1'b0;
        rsp_data.removed_value = '0;
        rsp_data.count         = rdb_pkg::t_count'(r_fill);
        case (r_state)
            rdb_pkg::ST_IDLE: begin
                if (req_accept) begin
                    case (i_req.kind)
                        rdb_pkg::KIND_PUSH_HEAD, rdb_pkg::KIND_PUSH_TAIL: begin
                            rsp_valid = 1'b1;
                            if (!full) begin
                                mem_en      = 1'b1;
                                mem_we      = 1'b1;
                                rsp_data.ok = 1'b1;
                                n_fill      = r_fill + 1'b1;
                                if (put_low) begin
                                    mem_addr = front_dec;
                                    n_front  = front_dec;
                                end else begin
                                    mem_addr = tail_addr;
                                end
                            end
                        end
                        rdb_pkg::KIND_POP_HEAD: begin
                            if (fill_nz) begin
                                // result comes out of the RAM next cycle
                                mem_en   = 1'b1;
                                mem_addr = r_rev ? tail_addr : r_front;
                                n_fill   = r_fill - 1'b1;
                                if (!r_rev) begin
                                    n_front = front_inc;
                                end
                            end else begin
                                rsp_valid = 1'b1;
                            end
                        end
                        rdb_pkg::KIND_REVERSE: begin
                            rsp_valid   = 1'b1;
                            rsp_data.ok = 1'b1;
                            n_rev       = !r_rev;
                        end
                        default: begin
                            rsp_valid = 1'b0;
                        end
                    endcase
                    rsp_data.count = rdb_pkg::t_count'(n_fill);
                end
            end
            rdb_pkg::ST_READ: begin
                rsp_valid              = 1'b1;
                rsp_data.ok            = 1'b1;
                rsp_data.removed_value = $signed(mem_rdata);
                rsp_data.count         = rdb_pkg::t_count'(r_fill);
            end
            default: begin
                rsp_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdb_pkg::ST_IDLE;
            r_front <= '0;
            r_fill  <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_fill  <= n_fill;
            r_rev   <= n_rev;
        end
    end

    rdb_ram #(
        .WIDTH (rdb_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_req.item_value),
        .o_rdata (mem_rdata)
    );

    rdb_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (rsp_valid),
        .i_data      (rsp_data),
        .o_skid_full (skid_full),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rdb_pkg::ST_READ |=> r_state == rdb_pkg::ST_IDLE)
        else $error("read state held past one cycle");

    a_read_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rdb_pkg::ST_READ |-> rsp_valid && rsp_data.ok)
        else $error("remove read produced no result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count above depth");

    a_pop_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept && (i_req.kind == rdb_pkg::KIND_POP_HEAD) && fill_nz
        |=> r_state == rdb_pkg::ST_READ && r_fill == $past(r_fill) - 1'b1)
        else $error("remove did not start a read");

    a_pop_empty_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept && (i_req.kind == rdb_pkg::KIND_POP_HEAD) && !fill_nz
        |-> rsp_valid && !rsp_data.ok && !mem_en)
        else $error("remove on empty not rejected");
`endif

endmodule
`default_nettype wire

// ----- tb/reversible_deque_buffer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_buffer_unit_tb: self-checking bench for the deque buffer
// Drives head/tail inserts, head removes and reverses through the request
// channel with random gaps. A scoreboard keeps its own ring store, head index,
// fill count and orientation, predicts each response beat, and compares it
// field by field with what the block returns under random back-pressure.
// ----------------------------------------------------------------------------
module reversible_deque_buffer_unit_tb;
    import rdb_pkg::*;

    localparam int DEPTH   = 256;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int IDLE_PCT = 29;

    // ------------------------------------------------------------------------
    // Scoreboard: deque predictor plus the queue of pending responses
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        t_value           store [DEPTH];
        logic [IDX_W-1:0] head_idx;
        t_count           fill;
        logic             flipped;
        t_rsp             rsp_q [$];
        int unsigned      n_fail;

        function new();
            head_idx = '0;
            fill     = '0;
            flipped  = 1'b0;
            n_fail   = 0;
        endfunction

        function int pending();
            return rsp_q.size();
        endfunction

        // Apply one accepted request beat and queue its expected response.
        function void note_request(t_kind kind, t_value value);
            t_rsp             rsp;
            logic [IDX_W-1:0] slot;
            rsp = '0;
            case (kind)
                KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
                    if (fill < t_count'(DEPTH)) begin
                        // head insert goes low in normal orientation, high when flipped
                        if ((kind == KIND_PUSH_HEAD) != flipped) begin
                            head_idx        = head_idx - 1'b1;
                            store[head_idx] = value;
                        end else begin
                            slot        = head_idx + IDX_W'(fill);
                            store[slot] = value;
                        end
                        fill   = fill + 1'b1;
                        rsp.ok = 1'b1;
                    end
                end
                KIND_POP_HEAD: begin
                    if (fill != '0) begin
                        if (!flipped) begin
                            rsp.removed_value = store[head_idx];
                            head_idx          = head_idx + 1'b1;
                        end else begin
                            slot              = head_idx + IDX_W'(fill - 1'b1);
                            rsp.removed_value = store[slot];
                        end
                        fill   = fill - 1'b1;
                        rsp.ok = 1'b1;
                    end
                end
                default: begin
                    flipped = ~flipped;
                    rsp.ok  = 1'b1;
                end
            endcase
            rsp.count = fill;
            rsp_q.push_back(rsp);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            n_fail++;
        endtask

        task check_result(logic ok, t_value value, t_count count);
            t_rsp exp_rsp;
            if (rsp_q.size() == 0) begin
                report($sformatf("unexpected response ok=%0b value=%0d count=%0d",
                                 ok, value, count));
            end else begin
                exp_rsp = rsp_q.pop_front();
                if (ok !== exp_rsp.ok)
                    report($sformatf("ok: got %0b, want %0b", ok, exp_rsp.ok));
                if (value !== exp_rsp.removed_value)
                    report($sformatf("removed_value: got %0d, want %0d",
                                     value, exp_rsp.removed_value));
                if (count !== exp_rsp.count)
                    report($sformatf("count: got %0d, want %0d", count, exp_rsp.count));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;
    logic no_idle;

    rdb_req_if req_if ();
    rdb_rsp_if rsp_if ();

    deque_scoreboard sb;

    reversible_deque_buffer_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Response side: random back-pressure and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.ok, rsp_if.removed_value, rsp_if.count);
        rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task send_request(t_kind kind, t_value value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.item_value <= value;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_request(kind, value);
    endtask

    function t_kind pick_kind(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return $urandom_range(1) ? KIND_PUSH_TAIL : KIND_PUSH_HEAD;
        else if (roll < push_pct + pop_pct)
            return KIND_POP_HEAD;
        else
            return KIND_REVERSE;
    endfunction

    task send_random(int push_pct, int pop_pct);
        send_request(pick_kind(push_pct, pop_pct), t_value'($urandom));
    endtask

    initial begin
        sb                = new();
        no_idle           = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_PUSH_HEAD;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-queue cases, value extremes, both orientations
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_REVERSE,   t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_REVERSE,   t_value'($urandom));
        send_request(KIND_PUSH_HEAD, 32'sh7FFF_FFFF);
        send_request(KIND_PUSH_TAIL, 32'sh8000_0000);
        send_request(KIND_PUSH_HEAD, 32'sh0000_0000);
        send_request(KIND_PUSH_TAIL, 32'shFFFF_FFFF);
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_REVERSE,   t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_PUSH_HEAD, 32'sh5555_5555);
        send_request(KIND_PUSH_TAIL, 32'shAAAA_AAAA);
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_REVERSE,   t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));
        send_request(KIND_PUSH_TAIL, 32'sh0000_0001);
        send_request(KIND_REVERSE,   t_value'($urandom));
        send_request(KIND_POP_HEAD,  t_value'($urandom));

        // balanced mix on a shallow queue
        repeat (30) send_random(45, 40);

        // hold off until the block has drained every response
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);

        // fill to the brim, first part without any idle cycles
        no_idle = 1'b1;
        repeat (120) send_random(95, 3);
        no_idle = 1'b0;
        while (sb.fill < t_count'(DEPTH))
            send_random(95, 3);
        // hammer the full queue: failed inserts mixed with the odd pop
        repeat (12) send_random(80, 10);

        // drain past empty
        while (sb.fill != '0)
            send_random(3, 95);
        repeat (8) send_random(10, 80);

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("** reversible_deque_buffer_unit: PASSED **");
        end else begin
            $display("** reversible_deque_buffer_unit: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #500000;
        $display("** reversible_deque_buffer_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rdb_pkg.sv
rtl/rdb_req_if.sv
rtl/rdb_rsp_if.sv
rtl/rdb_ram.sv
rtl/rdb_out_skid.sv
rtl/reversible_deque_buffer_unit.sv
tb/reversible_deque_buffer_unit_tb.sv
